// ===== hw/rtl/mrfe_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte step for the report frame encoder.
// No dependencies.

package mrfe_pkg;

   localparam int unsigned MAX_WORDS_DEF   = 127;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [BYTE_W-1:0] SLAVE_ID  = 8'h01;
   localparam logic [BYTE_W-1:0] FUNC_CODE = 8'h46;
   localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
   localparam logic [15:0]       CRC_POLY  = 16'hA001;

   // One queued command: a data word, possibly opening and/or closing a frame
   typedef struct packed {
      logic               first;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  addr;
      logic [WORD_W-1:0]  word;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_SLAVE,
      PH_FUNC,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_ZERO,
      PH_COUNT,
      PH_DOUBLE,
      PH_DATA_HI,
      PH_DATA_LO,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   // Reflected CRC-16 over one byte, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/mrfe_if.sv =====
// Valid/ready channel interfaces: word items in, frame bytes out.
// Depends on mrfe_pkg for field widths.

interface mrfe_req_if import mrfe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [COUNT_W-1:0]  word_count;
   logic [ADDR_W-1:0]   register_address;

   modport source (output valid, data_word, word_count, register_address, input ready);
   modport sink   (input valid, data_word, word_count, register_address, output ready);
endinterface

interface mrfe_rsp_if import mrfe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   frame_byte;
   logic                frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== hw/rtl/modbus_report_frame_encoder_top.sv =====
// Report frame encoder top level: front end, command queue and byte serialiser.
// Depends on mrfe_pkg, mrfe_if, mrfe_front, mrfe_queue and mrfe_back.
//
// Usage:
//   req_chan carries one 16-bit data word per item. On the first item of a frame
//   word_count (saturated to MAX_WORDS) and register_address are also taken.
//   rsp_chan carries one frame byte per item; frame_end marks the last CRC byte.
//   A frame is: slave id, function code, address high/low, zero, count, twice
//   the count, then high/low byte of each word, then CRC-16/Modbus low/high.
// Output: an item's first byte reaches rsp_chan after the command queue and
//   the output register. Throughput: one byte per cycle from the serialiser
//   while rsp_chan is not stalled, so a word inside a frame gives 2 bytes, an
//   opening item 9 (11 with a one-word frame), a closing word 4. The
//   serialiser limits; the QUEUE_DEPTH queue lets req_chan accept meanwhile.
// Reset: frame closed, CRC at 0xFFFF, queue empty, rsp_chan idle.
// Stall: when rsp_chan.ready is low the output register holds its byte, the
//   serialiser stops, and req_chan.ready drops once the queue fills.

module modbus_report_frame_encoder_top import mrfe_pkg::*; #(
   parameter int unsigned MAX_WORDS   = MAX_WORDS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrfe_req_if.sink   req_chan,
   mrfe_rsp_if.source rsp_chan
);

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   mrfe_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   mrfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (q_full)
   );

   mrfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== hw/rtl/mrfe_front.sv =====
// Front end: accepts word items, tracks frame state and classifies each item.
// Depends on mrfe_pkg and mrfe_req_if.

module mrfe_front import mrfe_pkg::*; #(
   parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrfe_req_if.sink   req_chan,
   input  logic       q_full,
   output logic       push,
   output cmd_type    push_cmd
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_WORDS);

   logic               frame_open_ff, frame_open_in;
   logic [COUNT_W-1:0] words_left_ff, words_left_in;
   logic [COUNT_W-1:0] cnt_sat;
   logic [COUNT_W-1:0] left_next;
   logic               first, last;

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      cnt_sat = (req_chan.word_count > MaxCount) ? MaxCount : req_chan.word_count;
      if (!frame_open_ff) begin
         first     = 1'b1;
         left_next = cnt_sat - 1'b1;
         last      = (cnt_sat <= COUNT_W'(1));
      end else begin
         first     = 1'b0;
         left_next = words_left_ff - 1'b1;
         last      = (words_left_ff == COUNT_W'(1));
      end
      frame_open_in = push ? !last : frame_open_ff;
      words_left_in = push ? (last ? '0 : left_next) : words_left_ff;

      push_cmd.first = first;
      push_cmd.last  = last;
      push_cmd.count = cnt_sat;
      push_cmd.addr  = req_chan.register_address;
      push_cmd.word  = req_chan.data_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         words_left_ff <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         words_left_ff <= words_left_in;
      end
   end

   // Open frame always expects at least one more word, closed frame none
   a_open_left: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (words_left_ff != '0))
      else $error("frame state and word count disagree");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      words_left_ff < MaxCount)
      else $error("words left beyond limit");

endmodule

// ===== hw/rtl/mrfe_queue.sv =====
// Short FIFO of classified commands between front and back ends.
// Depends on mrfe_pkg.

module mrfe_queue import mrfe_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign full       = (count_ff == FullCnt);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count out of range");

endmodule

// ===== hw/rtl/mrfe_back.sv =====
// Back end: serialises each command into frame bytes, runs the CRC, holds the output register.
// Depends on mrfe_pkg and mrfe_rsp_if.

module mrfe_back import mrfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   mrfe_rsp_if.source rsp_chan
);

   phase_type          phase_ff, phase_in;
   phase_type          cur_phase, next_phase;
   logic [15:0]        crc_ff, crc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               end_ff, end_in;
   logic [BYTE_W-1:0]  out_byte;
   logic               out_end;
   logic               done;
   logic               emit;
   logic [15:0]        crc_src;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = byte_ff;
   assign rsp_chan.frame_end  = end_ff;

   assign emit = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop  = emit && done;

   always_comb begin
      if (phase_ff == PH_START) begin
         cur_phase = head_cmd.first ? PH_SLAVE : PH_DATA_HI;
      end else begin
         cur_phase = phase_ff;
      end

      out_end = 1'b0;
      done    = 1'b0;
      case (cur_phase)
         PH_SLAVE: begin
            out_byte   = SLAVE_ID;
            next_phase = PH_FUNC;
         end
         PH_FUNC: begin
            out_byte   = FUNC_CODE;
            next_phase = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            out_byte   = head_cmd.addr[15:8];
            next_phase = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            out_byte   = head_cmd.addr[7:0];
            next_phase = PH_ZERO;
         end
         PH_ZERO: begin
            out_byte   = '0;
            next_phase = PH_COUNT;
         end
         PH_COUNT: begin
            out_byte   = {1'b0, head_cmd.count};
            next_phase = PH_DOUBLE;
         end
         PH_DOUBLE: begin
            // empty frame goes straight to the CRC
            out_byte   = {head_cmd.count, 1'b0};
            next_phase = (head_cmd.count == '0) ? PH_CRC_LO : PH_DATA_HI;
         end
         PH_DATA_HI: begin
            out_byte   = head_cmd.word[15:8];
            next_phase = PH_DATA_LO;
         end
         PH_DATA_LO: begin
            out_byte   = head_cmd.word[7:0];
            next_phase = head_cmd.last ? PH_CRC_LO : PH_START;
            done       = !head_cmd.last;
         end
         PH_CRC_LO: begin
            out_byte   = crc_ff[7:0];
            next_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            out_byte   = crc_ff[15:8];
            out_end    = 1'b1;
            next_phase = PH_START;
            done       = 1'b1;
         end
         default: begin
            out_byte   = '0;
            next_phase = PH_START;
         end
      endcase

      crc_src = (cur_phase == PH_SLAVE) ? CRC_INIT : crc_ff;

      phase_in     = phase_ff;
      crc_in       = crc_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (emit) begin
         phase_in     = next_phase;
         byte_in      = out_byte;
         end_in       = out_end;
         rsp_valid_in = 1'b1;
         if (cur_phase == PH_CRC_HI) begin
            crc_in = CRC_INIT;
         end else if (cur_phase != PH_CRC_LO) begin
            crc_in = crc_byte(crc_src, out_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   // Mid-command phases need the command still at the queue head
   a_phase_has_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_START) |-> head_valid)
      else $error("back end mid-command with empty queue");

   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cur_phase == PH_DATA_LO || cur_phase == PH_CRC_HI))
      else $error("command retired at wrong phase");

   a_crc_reinit: assert property (@(posedge clock) disable iff (reset)
      (emit && out_end) |=> (crc_ff == CRC_INIT))
      else $error("CRC not restarted after frame end");

endmodule
